FILE: design/mfat_pkg.sv
// Shared constants and types for the motor feedback angle tracker.
`timescale 1ns / 1ps
`default_nettype none

package mfat_pkg;

    localparam int unsigned ENCODER_MAX_DEF = 8191;

    // One full turn and half a turn in degrees, Q16
    localparam logic [24:0] FULL_TURN_Q16 = 25'd23592960;
    localparam logic [23:0] HALF_TURN_Q16 = 24'd11796480;

    // Gear ratio of 1.0 in Q8.16
    localparam logic [23:0] GEAR_ONE = 24'h010000;

    localparam logic [6:0] AMP_SCALE = 7'd80;

    // Shared divider geometry: two quotient bits per cycle
    localparam int unsigned DIV_NUM_W = 42;
    localparam int unsigned DIV_DEN_W = 24;
    localparam int unsigned DIV_ITERS = DIV_NUM_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

FILE: design/mfat_div.sv
// Shared restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mfat_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [mfat_pkg::DIV_NUM_W-1:0]      num,
    input  wire logic [mfat_pkg::DIV_DEN_W-1:0]      den,
    output logic      [mfat_pkg::DIV_NUM_W-1:0]      quot,
    output mfat_pkg::div_sts_t                       sts
);
    import mfat_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0]   step_a;
    logic [DIV_DEN_W:0]   step_b;

    // One compare-and-subtract: returns {quotient bit, new remainder}
    function automatic logic [DIV_DEN_W:0] div_step(
        input logic [DIV_DEN_W-1:0] rem,
        input logic                 bit_in,
        input logic [DIV_DEN_W-1:0] dv
    );
        logic [DIV_DEN_W:0]   r;
        logic [DIV_DEN_W:0]   d;
        logic [DIV_DEN_W:0]   res;
        r = {rem, bit_in};
        d = {1'b0, dv};
        if (r >= d)
        begin
            r   = r - d;
            res = {1'b1, r[DIV_DEN_W-1:0]};
        end
        else
        begin
            res = {1'b0, r[DIV_DEN_W-1:0]};
        end
        return res;
    endfunction

    always_comb
    begin
        step_a    = div_step(rem_reg, quo_reg[DIV_NUM_W-1], den_reg);
        step_b    = div_step(step_a[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-2], den_reg);
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = DIV_CNT_W'(DIV_ITERS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = step_b[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-3:0], step_a[DIV_DEN_W], step_b[DIV_DEN_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quot     = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

`default_nettype wire

FILE: design/motor_feedback_angle_tracker_top.sv
// Top level: frame sequencer, angle and shaft-angle state, output register.
// The shared divider runs twice per item (angle scaling, then gear ratio).
// Flow: the next item is taken as soon as the sequencer is back in idle,
// even while the previous result is stalled.
// Reset: asynchronous, active low; clears rotor angle, shaft angle, the
// sequencer and out_valid, and sets gear_ratio to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_angle_tracker_top #(
    parameter int unsigned ENCODER_MAX = mfat_pkg::ENCODER_MAX_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [23:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        encoder_count,
    input  wire logic signed [15:0] speed_raw,
    input  wire logic signed [15:0] current_raw,
    input  wire logic [7:0]         temperature_raw,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [24:0]             rotor_angle_deg,
    output logic signed [15:0]      rotor_speed_rpm,
    output logic signed [22:0]      current_amps,
    output logic [7:0]              temperature_c,
    output logic signed [24:0]      shaft_delta_deg,
    output logic signed [47:0]      shaft_angle_deg
);
    import mfat_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_MUL       = 7'b0000010,
        S_DIV_ANG   = 7'b0000100,
        S_WRAP      = 7'b0001000,
        S_DSTART    = 7'b0010000,
        S_DIV_SHAFT = 7'b0100000,
        S_ACC       = 7'b1000000
    } state_t;

    localparam logic [15:0] ENC_MAX_C = 16'(ENCODER_MAX);
    localparam logic signed [25:0] HALF_S = $signed({2'b00, HALF_TURN_Q16});
    localparam logic signed [25:0] FULL_S = $signed({1'b0, FULL_TURN_Q16});
    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    state_t state_reg, state_next;

    logic [23:0]        gear_reg;
    logic [24:0]        prev_angle_reg;
    logic signed [47:0] acc_reg;

    logic [15:0]        count_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] cur_reg;
    logic [7:0]         temp_reg;
    logic [24:0]        angle_reg;
    logic signed [25:0] delta_reg;
    logic signed [24:0] sd_reg;

    logic               out_valid_reg;
    logic [24:0]        o_angle_reg;
    logic signed [15:0] o_speed_reg;
    logic signed [22:0] o_amps_reg;
    logic [7:0]         o_temp_reg;
    logic signed [24:0] o_sd_reg;
    logic signed [47:0] o_acc_reg;

    logic               accept;
    logic               out_free;
    logic [40:0]        prod;
    logic signed [25:0] delta_raw;
    logic signed [25:0] delta_wrap;
    logic signed [25:0] delta_abs;
    logic [23:0]        ratio;
    logic               div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quot;
    div_sts_t           div_sts;
    logic [23:0]        q_mag;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic signed [22:0] amps;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign prod = 41'(count_reg) * 41'(FULL_TURN_Q16);

    // Wrap the rotor change into one half turn either way
    always_comb
    begin
        delta_raw = $signed({1'b0, angle_reg}) - $signed({1'b0, prev_angle_reg});
        if (delta_raw > HALF_S)
        begin
            delta_wrap = delta_raw - FULL_S;
        end
        else if (delta_raw < -HALF_S)
        begin
            delta_wrap = delta_raw + FULL_S;
        end
        else
        begin
            delta_wrap = delta_raw;
        end
    end

    assign delta_abs = delta_reg[25] ? -delta_reg : delta_reg;
    assign ratio     = (gear_reg[23:16] == 8'd0) ? GEAR_ONE : gear_reg;

    assign div_start = (state_reg == S_MUL) || (state_reg == S_DSTART);
    assign div_num   = (state_reg == S_MUL) ? {1'b0, prod}
                                            : {2'b00, delta_abs[23:0], 16'd0};
    assign div_den   = (state_reg == S_MUL) ? 24'(ENC_MAX_C) : ratio;

    mfat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .sts   (div_sts)
    );

    assign q_mag   = div_quot[23:0];
    assign acc_sum = 49'(acc_reg) + 49'(sd_reg);
    assign amps    = 23'(cur_reg) * $signed({16'd0, AMP_SCALE});

    always_comb
    begin
        if (acc_sum[48] != acc_sum[47])
        begin
            acc_sat = acc_sum[48] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[47:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV_ANG;
            end
            S_DIV_ANG:
            begin
                if (div_sts.done)
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DIV_SHAFT;
            end
            S_DIV_SHAFT:
            begin
                if (div_sts.done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gear_reg       <= GEAR_ONE;
            prev_angle_reg <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                gear_reg <= cfg_wr_data;
            end
            if (state_reg == S_WRAP)
            begin
                prev_angle_reg <= angle_reg;
            end
            if ((state_reg == S_ACC) && out_free)
            begin
                acc_reg       <= acc_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            // Clamp out-of-range counts to a full turn
            count_reg <= (encoder_count > ENC_MAX_C) ? ENC_MAX_C : encoder_count;
            speed_reg <= speed_raw;
            cur_reg   <= current_raw;
            temp_reg  <= temperature_raw;
        end
        if ((state_reg == S_DIV_ANG) && div_sts.done)
        begin
            angle_reg <= div_quot[24:0];
        end
        if (state_reg == S_WRAP)
        begin
            delta_reg <= delta_wrap;
        end
        if ((state_reg == S_DIV_SHAFT) && div_sts.done)
        begin
            sd_reg <= delta_reg[25] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        end
        if ((state_reg == S_ACC) && out_free)
        begin
            o_angle_reg <= angle_reg;
            o_speed_reg <= speed_reg;
            o_amps_reg  <= amps;
            o_temp_reg  <= temp_reg;
            o_sd_reg    <= sd_reg;
            o_acc_reg   <= acc_sat;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rotor_angle_deg = o_angle_reg;
    assign rotor_speed_rpm = o_speed_reg;
    assign current_amps    = o_amps_reg;
    assign temperature_c   = o_temp_reg;
    assign shaft_delta_deg = o_sd_reg;
    assign shaft_angle_deg = o_acc_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIV_ANG || state_reg == S_DIV_SHAFT))
        else $error("divider finished outside a wait state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MUL))
        else $error("accepted item did not start the sequence");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRAP) |-> (angle_reg <= FULL_TURN_Q16))
        else $error("rotor angle beyond a full turn");

    a_shaft_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |->
            (sd_reg <= $signed({1'b0, HALF_TURN_Q16}) &&
             sd_reg >= -$signed({1'b0, HALF_TURN_Q16})))
        else $error("shaft change larger than half a rotor turn");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && out_valid_reg && out_stall) |=> (state_reg == S_ACC))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: tb/sv/mfat_frame_checker.sv
// Checker: predicts the result of every accepted frame and compares it with the block output.
`timescale 1ns / 1ps

module mfat_frame_checker #(
    parameter int unsigned ENCODER_MAX = mfat_pkg::ENCODER_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [23:0]        cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [15:0]        encoder_count,
    input  logic signed [15:0] speed_raw,
    input  logic signed [15:0] current_raw,
    input  logic [7:0]         temperature_raw,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [24:0]        rotor_angle_deg,
    input  logic signed [15:0] rotor_speed_rpm,
    input  logic signed [22:0] current_amps,
    input  logic [7:0]         temperature_c,
    input  logic signed [24:0] shaft_delta_deg,
    input  logic signed [47:0] shaft_angle_deg,
    output int                 mismatches,
    output int                 pending
);
    import mfat_pkg::*;

    localparam longint SHAFT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SHAFT_MIN = -SHAFT_MAX - 1;

    typedef struct {
        logic [24:0]        rotor_angle;
        logic signed [15:0] speed;
        logic signed [22:0] amps;
        logic [7:0]         temp;
        logic signed [24:0] shaft_delta;
        logic signed [47:0] shaft_angle;
    } frame_result_t;

    frame_result_t expected_frames[$];
    frame_result_t want;
    logic [23:0]   gear_ratio_q;
    longint        last_rotor_angle;
    longint        shaft_total;
    int            n_accepted;
    int            n_returned;
    int            n_bad;

    assign pending    = n_accepted - n_returned;
    assign mismatches = n_bad;

    function automatic frame_result_t track_frame(
        input logic [15:0]        count,
        input logic signed [15:0] speed,
        input logic signed [15:0] code,
        input logic [7:0]         temp
    );
        frame_result_t r;
        longint clamped;
        longint angle;
        longint delta;
        longint ratio;
        longint mag;
        longint quot;
        longint shaft_step;
        longint total;
        clamped = count;
        if (clamped > longint'(ENCODER_MAX))
            clamped = longint'(ENCODER_MAX);
        angle = (clamped * longint'(FULL_TURN_Q16)) / longint'(ENCODER_MAX);

        // Wrap the change by a full turn when it passes half a turn
        delta = angle - last_rotor_angle;
        if (angle > last_rotor_angle)
        begin
            if (delta > longint'(HALF_TURN_Q16))
                delta = delta - longint'(FULL_TURN_Q16);
        end
        else if (delta < -longint'(HALF_TURN_Q16))
        begin
            delta = delta + longint'(FULL_TURN_Q16);
        end
        last_rotor_angle = angle;

        // Ratios below 1.0 count as 1.0; divide the magnitude to round toward zero
        ratio = gear_ratio_q;
        if (ratio < longint'(GEAR_ONE))
            ratio = longint'(GEAR_ONE);
        mag = (delta < 0) ? -delta : delta;
        quot = (mag * 65536) / ratio;
        shaft_step = (delta < 0) ? -quot : quot;

        total = shaft_total + shaft_step;
        if (total > SHAFT_MAX)
            total = SHAFT_MAX;
        if (total < SHAFT_MIN)
            total = SHAFT_MIN;
        shaft_total = total;

        r.rotor_angle = 25'(angle);
        r.speed       = speed;
        r.amps        = 23'(longint'(code) * longint'(AMP_SCALE));
        r.temp        = temp;
        r.shaft_delta = 25'(shaft_step);
        r.shaft_angle = 48'(total);
        return r;
    endfunction

    task automatic note_bad(input string what, input logic [63:0] want_v,
                            input logic [63:0] got_v);
        n_bad++;
        if (n_bad <= 10)
            $display("mismatch %0d on %s: expected %0h, got %0h", n_bad, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_ratio_q     = GEAR_ONE;
            last_rotor_angle = 0;
            shaft_total      = 0;
            n_bad            = 0;
            n_accepted      <= 0;
            n_returned      <= 0;
            expected_frames.delete();
        end
        else
        begin
            if (cfg_wr_en)
                gear_ratio_q = cfg_wr_data;

            if (in_valid && !in_stall)
            begin
                n_accepted <= n_accepted + 1;
                expected_frames.push_back(track_frame(encoder_count, speed_raw,
                                                      current_raw, temperature_raw));
            end

            if (out_valid && !out_stall)
            begin
                n_returned <= n_returned + 1;
                if (expected_frames.size() == 0)
                begin
                    note_bad("result with no item waiting", 64'd0, 64'd0);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (rotor_angle_deg !== want.rotor_angle)
                        note_bad("rotor_angle_deg", want.rotor_angle, rotor_angle_deg);
                    if (rotor_speed_rpm !== want.speed)
                        note_bad("rotor_speed_rpm", want.speed, rotor_speed_rpm);
                    if (current_amps !== want.amps)
                        note_bad("current_amps", want.amps, current_amps);
                    if (temperature_c !== want.temp)
                        note_bad("temperature_c", want.temp, temperature_c);
                    if (shaft_delta_deg !== want.shaft_delta)
                        note_bad("shaft_delta_deg", want.shaft_delta, shaft_delta_deg);
                    if (shaft_angle_deg !== want.shaft_angle)
                        note_bad("shaft_angle_deg", want.shaft_angle, shaft_angle_deg);
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_motor_feedback_angle_tracker_top.sv
// Testbench top: drives feedback frames and gear-ratio writes, and reports the verdict.
`timescale 1ns / 1ps

module tb_motor_feedback_angle_tracker_top;
    import mfat_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [23:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        encoder_count;
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
    logic [7:0]         temperature_raw;
    logic               out_valid;
    logic               out_stall;
    logic [24:0]        rotor_angle_deg;
    logic signed [15:0] rotor_speed_rpm;
    logic signed [22:0] current_amps;
    logic [7:0]         temperature_c;
    logic signed [24:0] shaft_delta_deg;
    logic signed [47:0] shaft_angle_deg;

    int          mismatches;
    int          pending;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    int          cycle_count;
    logic [15:0] prev_count     = 16'd0;

    motor_feedback_angle_tracker_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .encoder_count   (encoder_count),
        .speed_raw       (speed_raw),
        .current_raw     (current_raw),
        .temperature_raw (temperature_raw),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rotor_angle_deg (rotor_angle_deg),
        .rotor_speed_rpm (rotor_speed_rpm),
        .current_amps    (current_amps),
        .temperature_c   (temperature_c),
        .shaft_delta_deg (shaft_delta_deg),
        .shaft_angle_deg (shaft_angle_deg)
    );

    mfat_frame_checker u_frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .encoder_count   (encoder_count),
        .speed_raw       (speed_raw),
        .current_raw     (current_raw),
        .temperature_raw (temperature_raw),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rotor_angle_deg (rotor_angle_deg),
        .rotor_speed_rpm (rotor_speed_rpm),
        .current_amps    (current_amps),
        .temperature_c   (temperature_c),
        .shaft_delta_deg (shaft_delta_deg),
        .shaft_angle_deg (shaft_angle_deg),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL motor_feedback_angle_tracker_top");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_frame(input logic [15:0] count, input logic [15:0] speed,
                              input logic [15:0] code, input logic [7:0] temp);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        encoder_count   <= count;
        speed_raw       <= speed;
        current_raw     <= code;
        temperature_raw <= temp;
        prev_count = (count > 16'(ENCODER_MAX_DEF)) ? 16'(ENCODER_MAX_DEF) : count;
        // Hold the item until the block takes it
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_frame;
        int          pick;
        int          next;
        logic [15:0] count;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // Smooth motion, wrapping through zero
            next  = int'(prev_count) + int'($urandom_range(1200)) - 600;
            count = 16'(next & 8191);
        end
        else if (pick < 72)
        begin
            count = 16'($urandom_range(ENCODER_MAX_DEF));
        end
        else if (pick < 80)
        begin
            // Jump close to half a turn
            next  = int'(prev_count) + 4096 + int'($urandom_range(8)) - 4;
            count = 16'(next & 8191);
        end
        else if (pick < 85)
        begin
            count = $urandom_range(1) ? 16'(ENCODER_MAX_DEF) : 16'd0;
        end
        else
        begin
            count = 16'($urandom);
        end
        send_frame(count, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_gear(input logic [23:0] ratio);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ratio;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [23:0] ratio;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 24'd0;
        in_valid        = 1'b0;
        encoder_count   = 16'd0;
        speed_raw       = 16'sd0;
        current_raw     = 16'sd0;
        temperature_raw = 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 22;
        recv_stall_pct = 54;

        // Directed frames at the reset gear ratio; the first is taken against angle zero
        send_frame(16'd3000, 16'h0000, 16'h0000, 8'h00);
        send_frame(16'd0,    16'h7FFF, 16'h7FFF, 8'hFF);
        send_frame(16'd8191, 16'h8000, 16'h8000, 8'h00);
        send_frame(16'hFFFF, 16'h5555, 16'hAAAA, 8'h55);
        send_frame(16'd8192, 16'hAAAA, 16'h5555, 8'hAA);
        send_frame(16'd0,    16'h0001, 16'hFFFF, 8'h01);
        send_frame(16'd4096, 16'hFFFF, 16'h0001, 8'hFE);
        send_frame(16'd8191, 16'h1234, 16'h4000, 8'h7F);
        send_frame(16'd4095, 16'hEDCB, 16'hC000, 8'h80);
        send_frame(16'd1,    16'h8000, 16'h8000, 8'h80);
        send_frame(16'd2000, 16'h7FFF, 16'h7FFF, 8'h3C);
        send_frame(16'd6500, 16'h0100, 16'hFF00, 8'h10);
        send_frame(16'd2000, 16'hFF00, 16'h0100, 8'h20);
        send_frame(16'hAAAA, 16'h0000, 16'h0000, 8'h00);
        send_frame(16'h5555, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_frame(16'd0,    16'h0000, 16'h0000, 8'h00);
        send_frame(16'd2048, 16'h0002, 16'hFFFE, 8'h02);
        send_frame(16'd6143, 16'h0003, 16'hFFFD, 8'h03);
        send_frame(16'd2047, 16'h0004, 16'hFFFC, 8'h04);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: ratio = GEAR_ONE;
                1: ratio = 24'hFFFFFF;
                2: ratio = 24'd0;
                3: ratio = 24'($urandom_range(24'hFFFFFF, 24'h010000));
                4: ratio = 24'd65535;
                default: ratio = 24'($urandom_range(24'h100000, 24'h010000));
            endcase
            write_gear(ratio);
            if (phase < 2)
            begin
                send_gap_pct   = 22;
                recv_stall_pct = 54;
            end
            else if (phase < 4)
            begin
                send_gap_pct   = 54;
                recv_stall_pct = 22;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Long receiver hold-off while frames keep coming, to back up the block
                if (phase == 1 && i == 100)
                    hold_left = HOLD_CYCLES;
                send_random_frame();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS motor_feedback_angle_tracker_top");
        else
            $display("FAIL motor_feedback_angle_tracker_top");
        $finish;
    end

endmodule
